[design/timestamp_delta_of_delta_encoder_macros.svh]
// assertion macros for the timestamp delta-of-delta encoder
// used by the modules that carry concurrent checks; no other dependencies
`ifndef TIMESTAMP_DELTA_OF_DELTA_ENCODER_MACROS_SVH
`define TIMESTAMP_DELTA_OF_DELTA_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TSDOD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsdod: same-cycle check failed");

// next-cycle implication, checked outside reset
`define TSDOD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsdod: next-cycle check failed");

`endif

[design/tsdod_pkg.sv]
// shared types and constants for the timestamp delta-of-delta encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsdod_pkg;

  localparam int STAMP_W    = 64;
  localparam int PFX_CODE_W = 5;
  localparam int PFX_LEN_W  = 3;
  localparam int PAY_LEN_W  = 7;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PFX_CODE_W-1:0] PFX_NONE = 5'b00000;
  localparam logic [PFX_CODE_W-1:0] PFX_ZERO = 5'b00000;
  localparam logic [PFX_CODE_W-1:0] PFX_W7   = 5'b00010;
  localparam logic [PFX_CODE_W-1:0] PFX_W9   = 5'b00110;
  localparam logic [PFX_CODE_W-1:0] PFX_W12  = 5'b01110;
  localparam logic [PFX_CODE_W-1:0] PFX_W32  = 5'b11110;
  localparam logic [PFX_CODE_W-1:0] PFX_W64  = 5'b11111;

  localparam logic [PFX_LEN_W-1:0] PLEN_NONE = 3'd0;
  localparam logic [PFX_LEN_W-1:0] PLEN_ZERO = 3'd1;
  localparam logic [PFX_LEN_W-1:0] PLEN_W7   = 3'd2;
  localparam logic [PFX_LEN_W-1:0] PLEN_W9   = 3'd3;
  localparam logic [PFX_LEN_W-1:0] PLEN_W12  = 3'd4;
  localparam logic [PFX_LEN_W-1:0] PLEN_W32  = 3'd5;
  localparam logic [PFX_LEN_W-1:0] PLEN_W64  = 3'd5;

  localparam logic [PAY_LEN_W-1:0] DLEN_ZERO = 7'd0;
  localparam logic [PAY_LEN_W-1:0] DLEN_W7   = 7'd7;
  localparam logic [PAY_LEN_W-1:0] DLEN_W9   = 7'd9;
  localparam logic [PAY_LEN_W-1:0] DLEN_W12  = 7'd12;
  localparam logic [PAY_LEN_W-1:0] DLEN_W32  = 7'd32;
  localparam logic [PAY_LEN_W-1:0] DLEN_W64  = 7'd64;

  // one classified beat: raw stamp when first, else the delta-of-delta
  typedef struct packed {
    logic               first;
    logic [STAMP_W-1:0] value;
  } tsdod_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tsdod_qstat_t;

endpackage

`default_nettype wire

[design/tsdod_front.sv]
// front end: accepts stamps, keeps last stamp and delta, forms delta-of-delta
// depends on tsdod_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsdod_front
  import tsdod_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  input  wire logic signed [STAMP_W-1:0] in_stamp,
  input  wire tsdod_qstat_t              q_stat,
  output logic                           q_push,
  output tsdod_item_t                    q_item
);

  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic [STAMP_W-1:0] last_delta_r, last_delta_nxt;
  logic               first_r, first_nxt;
  logic [STAMP_W-1:0] stamp_u;
  logic [STAMP_W-1:0] delta;
  logic [STAMP_W-1:0] dod;

  assign stamp_u = in_stamp;
  assign q_push  = in_push && !q_stat.full;

  // both differences wrap modulo 2^64
  assign delta = stamp_u - last_stamp_r;
  assign dod   = delta - last_delta_r;

  always_comb begin
    q_item.first   = first_r;
    q_item.value   = first_r ? stamp_u : dod;
    last_stamp_nxt = last_stamp_r;
    last_delta_nxt = last_delta_r;
    first_nxt      = first_r;
    if (q_push) begin
      last_stamp_nxt = stamp_u;
      first_nxt      = 1'b0;
      // first beat leaves the delta as it was
      if (!first_r) begin
        last_delta_nxt = delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      last_delta_r <= '0;
      first_r      <= 1'b1;
    end else begin
      last_stamp_r <= last_stamp_nxt;
      last_delta_r <= last_delta_nxt;
      first_r      <= first_nxt;
    end
  end

endmodule

`default_nettype wire

[design/tsdod_queue.sv]
// short register queue between front and back
// depends on tsdod_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

module tsdod_queue
  import tsdod_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire tsdod_item_t  push_item,
  input  wire logic         pop,
  output tsdod_item_t       head_item,
  output tsdod_qstat_t      stat
);

  `include "timestamp_delta_of_delta_encoder_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tsdod_item_t       entry_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign stat.full  = (count_r == FULL_CNT);
  assign stat.empty = (count_r == '0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `TSDOD_ASSERT_IMP(a_no_push_full, clk, rst_n, stat.full, !push)
  `TSDOD_ASSERT_IMP(a_no_pop_empty, clk, rst_n, stat.empty, !pop)
  `TSDOD_ASSERT_NXT(a_count_grows, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

`default_nettype wire

[design/tsdod_back.sv]
// back end: picks the code for each beat and holds it in the output register
// depends on tsdod_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsdod_back
  import tsdod_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tsdod_item_t        head_item,
  input  wire tsdod_qstat_t       q_stat,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [PFX_CODE_W-1:0]   out_prefix_code,
  output logic [PFX_LEN_W-1:0]    out_prefix_length,
  output logic [STAMP_W-1:0]      out_payload_code,
  output logic [PAY_LEN_W-1:0]    out_payload_length
);

  logic                  valid_r, valid_nxt;
  logic [PFX_CODE_W-1:0] pcode_r, pcode_nxt;
  logic [PFX_LEN_W-1:0]  plen_r, plen_nxt;
  logic [STAMP_W-1:0]    dcode_r, dcode_nxt;
  logic [PAY_LEN_W-1:0]  dlen_r, dlen_nxt;
  logic [STAMP_W-1:0]    v;
  logic                  fit7, fit9, fit12, fit32;

  assign v = head_item.value;

  // a value fits n bits signed when bits 63..n-1 all match
  assign fit7  = (&v[STAMP_W-1:6])  || !(|v[STAMP_W-1:6]);
  assign fit9  = (&v[STAMP_W-1:8])  || !(|v[STAMP_W-1:8]);
  assign fit12 = (&v[STAMP_W-1:11]) || !(|v[STAMP_W-1:11]);
  assign fit32 = (&v[STAMP_W-1:31]) || !(|v[STAMP_W-1:31]);

  // load when the output register is free or being drained this cycle
  assign q_pop     = !q_stat.empty && (!valid_r || out_pop);
  assign valid_nxt = q_pop || (valid_r && !out_pop);
  assign out_empty = !valid_r;

  always_comb begin
    if (head_item.first) begin
      pcode_nxt = PFX_NONE; plen_nxt = PLEN_NONE; dcode_nxt = v;  dlen_nxt = DLEN_W64;
    end else if (v == '0) begin
      pcode_nxt = PFX_ZERO; plen_nxt = PLEN_ZERO; dcode_nxt = '0; dlen_nxt = DLEN_ZERO;
    end else if (fit7) begin
      pcode_nxt = PFX_W7;   plen_nxt = PLEN_W7;
      dcode_nxt = {57'd0, v[6:0]};   dlen_nxt = DLEN_W7;
    end else if (fit9) begin
      pcode_nxt = PFX_W9;   plen_nxt = PLEN_W9;
      dcode_nxt = {55'd0, v[8:0]};   dlen_nxt = DLEN_W9;
    end else if (fit12) begin
      pcode_nxt = PFX_W12;  plen_nxt = PLEN_W12;
      dcode_nxt = {52'd0, v[11:0]};  dlen_nxt = DLEN_W12;
    end else if (fit32) begin
      pcode_nxt = PFX_W32;  plen_nxt = PLEN_W32;
      dcode_nxt = {32'd0, v[31:0]};  dlen_nxt = DLEN_W32;
    end else begin
      pcode_nxt = PFX_W64;  plen_nxt = PLEN_W64; dcode_nxt = v;  dlen_nxt = DLEN_W64;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pcode_r <= pcode_nxt;
      plen_r  <= plen_nxt;
      dcode_r <= dcode_nxt;
      dlen_r  <= dlen_nxt;
    end
  end

  assign out_prefix_code    = pcode_r;
  assign out_prefix_length  = plen_r;
  assign out_payload_code   = dcode_r;
  assign out_payload_length = dlen_r;

endmodule

`default_nettype wire

[design/timestamp_delta_of_delta_encoder.sv]
// timestamp delta-of-delta encoder top level: front, queue, back
// a queued beat moves into the output register, and so onto the out_ ports, once that register is free or being drained
// throughput: one beat per cycle while out_pop drains; the two chained front subtracts set the clock
// reset: rst_n low clears last stamp and delta to zero, re-arms the first-beat raw form
// and empties the queue and output register; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module timestamp_delta_of_delta_encoder
  import tsdod_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic signed [STAMP_W-1:0] in_stamp,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [PFX_CODE_W-1:0]          out_prefix_code,
  output logic [PFX_LEN_W-1:0]           out_prefix_length,
  output logic [STAMP_W-1:0]             out_payload_code,
  output logic [PAY_LEN_W-1:0]           out_payload_length
);

  tsdod_qstat_t q_stat;
  tsdod_item_t  push_item;
  tsdod_item_t  head_item;
  logic         q_push;
  logic         q_pop;

  assign in_full = q_stat.full;

  tsdod_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_stamp (in_stamp),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  tsdod_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  tsdod_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_item          (head_item),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_prefix_code    (out_prefix_code),
    .out_prefix_length  (out_prefix_length),
    .out_payload_code   (out_payload_code),
    .out_payload_length (out_payload_length)
  );

endmodule

`default_nettype wire
